/* rtl/mfat_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfat_pkg: shared types and constants of the motor feedback angle tracker
// motor groups, field widths, register indexes, queue item and control types
// ----------------------------------------------------------------------------
package mfat_pkg;

  localparam int CHASSIS_MOTORS  = 4;
  localparam int LAUNCHER_MOTORS = 2;
  localparam int COUNTS_PER_TURN = 8192;

  localparam int NUM_MOTORS = CHASSIS_MOTORS + LAUNCHER_MOTORS + 3;
  localparam int IDX_W      = $clog2(NUM_MOTORS);
  localparam int POKE_IDX   = CHASSIS_MOTORS + LAUNCHER_MOTORS;
  localparam int PITCH_IDX  = POKE_IDX + 1;
  localparam int YAW_IDX    = POKE_IDX + 2;

  localparam int ID_W       = 11;
  localparam int ANG_W      = 16;
  localparam int WORD_W     = 16;
  localparam int BYTE_W     = 8;
  localparam int CNT_W      = 8;
  localparam int TURN_W     = 32;
  localparam int OUT_IDX_W  = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  // queue depth, a power of two so the pointers wrap on their own
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam logic [ID_W-1:0]  RST_CHASSIS_BASE  = 11'd513;
  localparam logic [ID_W-1:0]  RST_LAUNCHER_BASE = 11'd517;
  localparam logic [ID_W-1:0]  RST_POKE_ID       = 11'd519;
  localparam logic [ID_W-1:0]  RST_PITCH_ID      = 11'd522;
  localparam logic [ID_W-1:0]  RST_YAW_ID        = 11'd521;
  localparam logic [CNT_W-1:0] RST_CALIB         = 8'd50;
  localparam logic [CNT_W-1:0] CNT_MAX           = 8'd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHASSIS_BASE  = 3'd0,
    CFG_LAUNCHER_BASE = 3'd1,
    CFG_POKE_ID       = 3'd2,
    CFG_PITCH_ID      = 3'd3,
    CFG_YAW_ID        = 3'd4,
    CFG_CALIB         = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [ID_W-1:0]  chassis_base;
    logic [ID_W-1:0]  launcher_base;
    logic [ID_W-1:0]  poke_id;
    logic [ID_W-1:0]  pitch_id;
    logic [ID_W-1:0]  yaw_id;
    logic [CNT_W-1:0] calib_messages;
  } cfg_t;

  typedef struct packed {
    logic                     matched;
    logic [IDX_W-1:0]         idx;
    logic [ANG_W-1:0]         angle;
    logic signed [WORD_W-1:0] second_word;
    logic signed [WORD_W-1:0] third_word;
    logic [BYTE_W-1:0]        sixth_byte;
  } item_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_UPDATE,
    BK_EMIT
  } bk_state_e;

endpackage

/* rtl/mfat_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfat_front: input side of the tracker
// takes frame beats, maps the identifier to a motor and pushes the queue
// ----------------------------------------------------------------------------
module mfat_front (
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [mfat_pkg::ID_W-1:0]         frame_id_i,
  input  logic [mfat_pkg::ANG_W-1:0]        angle_word_i,
  input  logic signed [mfat_pkg::WORD_W-1:0] second_word_i,
  input  logic signed [mfat_pkg::WORD_W-1:0] third_word_i,
  input  logic [mfat_pkg::BYTE_W-1:0]       sixth_byte_i,
  input  mfat_pkg::cfg_t                    cfg_i,
  input  mfat_pkg::q_stat_t                 q_stat_i,
  output logic                              push_o,
  output mfat_pkg::item_t                   item_o
);
  import mfat_pkg::*;

  logic [ID_W-1:0] ch_off;
  logic [ID_W-1:0] la_off;
  logic            ch_hit;
  logic            la_hit;

  assign ch_off = frame_id_i - cfg_i.chassis_base;
  assign la_off = frame_id_i - cfg_i.launcher_base;
  assign ch_hit = (frame_id_i >= cfg_i.chassis_base) &&
                  (ch_off < ID_W'(CHASSIS_MOTORS));
  assign la_hit = (frame_id_i >= cfg_i.launcher_base) &&
                  (la_off < ID_W'(LAUNCHER_MOTORS));

  // priority: chassis, launcher, poke, pitch, yaw
  always_comb begin
    item_o.matched     = 1'b1;
    item_o.idx         = '0;
    item_o.angle       = angle_word_i;
    item_o.second_word = second_word_i;
    item_o.third_word  = third_word_i;
    item_o.sixth_byte  = sixth_byte_i;
    if (ch_hit) begin
      item_o.idx = IDX_W'(ch_off);
    end else if (la_hit) begin
      item_o.idx = IDX_W'(CHASSIS_MOTORS) + IDX_W'(la_off);
    end else if (frame_id_i == cfg_i.poke_id) begin
      item_o.idx = IDX_W'(POKE_IDX);
    end else if (frame_id_i == cfg_i.pitch_id) begin
      item_o.idx = IDX_W'(PITCH_IDX);
    end else if (frame_id_i == cfg_i.yaw_id) begin
      item_o.idx = IDX_W'(YAW_IDX);
    end else begin
      item_o.matched = 1'b0;
    end
  end

  assign in_stall_o = q_stat_i.full;
  assign push_o     = in_valid_i && !q_stat_i.full;

endmodule

/* rtl/mfat_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfat_queue: short queue between front and back
// holds classified frames so either side can stall on its own
// ----------------------------------------------------------------------------
module mfat_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  mfat_pkg::item_t    item_i,
  input  logic               pop_i,
  output mfat_pkg::item_t    head_o,
  output mfat_pkg::q_stat_t  stat_o
);
  import mfat_pkg::*;

  item_t             slot_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]   count_q, count_d;

  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (count_q == (QPTR_W+1)'(QDEPTH));
  assign head_o       = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

/* rtl/mfat_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfat_back: per-motor tracking and result register
// read-modify-write of the motor entry, total angle, decoded result beat
// ----------------------------------------------------------------------------
module mfat_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [mfat_pkg::CNT_W-1:0]          calib_messages_i,
  input  mfat_pkg::q_stat_t                   q_stat_i,
  input  mfat_pkg::item_t                     head_i,
  output logic                                pop_o,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                matched_o,
  output logic [mfat_pkg::OUT_IDX_W-1:0]      motor_index_o,
  output logic                                calibrating_o,
  output logic [mfat_pkg::ANG_W-1:0]          angle_o,
  output logic signed [mfat_pkg::TURN_W-1:0]  round_count_o,
  output logic signed [mfat_pkg::TURN_W-1:0]  total_angle_o,
  output logic signed [mfat_pkg::WORD_W-1:0]  speed_rpm_o,
  output logic signed [mfat_pkg::WORD_W-1:0]  torque_current_o,
  output logic signed [mfat_pkg::WORD_W-1:0]  given_current_o,
  output logic [mfat_pkg::BYTE_W-1:0]         temperature_o
);
  import mfat_pkg::*;

  localparam logic signed [ANG_W:0] HALF_TURN     = (ANG_W+1)'(COUNTS_PER_TURN / 2);
  localparam logic signed [ANG_W:0] NEG_HALF_TURN = -HALF_TURN;

  bk_state_e state_q, state_d;

  // per-motor entries
  logic [CNT_W-1:0]  cnt_q    [NUM_MOTORS];
  logic [ANG_W-1:0]  last_q   [NUM_MOTORS];
  logic [TURN_W-1:0] turn_q   [NUM_MOTORS];
  logic [ANG_W-1:0]  offset_q [NUM_MOTORS];

  item_t             work_q;
  logic              cal_q;
  logic [TURN_W-1:0] turn_new_q;
  logic [ANG_W-1:0]  off_q;

  logic              out_valid_q, out_valid_d;
  logic              load;
  logic              upd;

  logic [CNT_W-1:0]     prior;
  logic                 is_cal;
  logic signed [ANG_W:0] diff;
  logic [TURN_W-1:0]    turn_cur;
  logic [TURN_W-1:0]    turn_nx;

  logic [TURN_W-1:0]    total;
  logic                 chassis_type;
  logic                 live;
  logic [31:0]          idx_ext;

  // entry read and unwrap
  always_comb begin
    prior    = cnt_q[work_q.idx];
    turn_cur = turn_q[work_q.idx];
    is_cal   = (prior <= calib_messages_i);
    diff     = $signed({1'b0, work_q.angle}) - $signed({1'b0, last_q[work_q.idx]});
    turn_nx  = turn_cur;
    if (!is_cal) begin
      if (diff > HALF_TURN) begin
        turn_nx = turn_cur - 1'b1;
      end else if (diff < NEG_HALF_TURN) begin
        turn_nx = turn_cur + 1'b1;
      end
    end
  end

  // sequencer: take a frame, update its motor, emit the result beat
  always_comb begin
    state_d = state_q;
    pop_o   = 1'b0;
    upd     = 1'b0;
    load    = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (!q_stat_i.empty) begin
          pop_o   = 1'b1;
          state_d = BK_UPDATE;
        end
      end
      BK_UPDATE: begin
        upd     = work_q.matched;
        state_d = BK_EMIT;
      end
      BK_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          load    = 1'b1;
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_MOTORS; i++) begin
        cnt_q[i]    <= '0;
        last_q[i]   <= '0;
        turn_q[i]   <= '0;
        offset_q[i] <= '0;
      end
    end else if (upd) begin
      if (prior != CNT_MAX) begin
        cnt_q[work_q.idx] <= prior + 1'b1;
      end
      last_q[work_q.idx] <= work_q.angle;
      turn_q[work_q.idx] <= turn_nx;
      if (is_cal) begin
        offset_q[work_q.idx] <= work_q.angle;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      work_q <= head_i;
    end
    if (state_q == BK_UPDATE) begin
      cal_q      <= is_cal;
      turn_new_q <= turn_nx;
      off_q      <= is_cal ? work_q.angle : offset_q[work_q.idx];
    end
  end

  // result decode
  assign total = TURN_W'(turn_new_q * TURN_W'(COUNTS_PER_TURN)) +
                 TURN_W'(work_q.angle) - TURN_W'(off_q);
  assign chassis_type = (work_q.idx < IDX_W'(PITCH_IDX));
  assign live         = work_q.matched && !cal_q;
  assign idx_ext      = 32'(work_q.idx);

  always_ff @(posedge clk_i) begin
    if (load) begin
      matched_o        <= work_q.matched;
      motor_index_o    <= work_q.matched ? idx_ext[OUT_IDX_W-1:0] : '0;
      calibrating_o    <= work_q.matched && cal_q;
      angle_o          <= work_q.matched ? work_q.angle : '0;
      round_count_o    <= work_q.matched ? $signed(turn_new_q) : '0;
      total_angle_o    <= live ? $signed(total) : '0;
      speed_rpm_o      <= (live && chassis_type) ? work_q.second_word : '0;
      torque_current_o <= !live ? '0 :
                          chassis_type ? work_q.third_word : work_q.second_word;
      given_current_o  <= (live && !chassis_type) ? work_q.third_word : '0;
      temperature_o    <= (live && chassis_type) ? work_q.sixth_byte : '0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* rtl/motor_feedback_angle_tracker_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motor_feedback_angle_tracker_top: motor feedback angle tracker
// maps feedback frames to nine motors, unwraps angles, decodes payload words
// ----------------------------------------------------------------------------
// path: input beat, queue slot, back work register, update step, result beat
// the back takes a new frame only once its take / read-modify-write / emit
//   steps on the shared motor entry for the last one are done
// the 2-deep queue takes new beats while the back stalls on its output
// reset: asynchronous, active low; clears all motor entries, queue and control,
//   loads the identifier and calibration registers with their defaults
// ----------------------------------------------------------------------------
module motor_feedback_angle_tracker_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration
  input  logic                                cfg_we_i,
  input  logic [mfat_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [mfat_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  // frame input
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [mfat_pkg::ID_W-1:0]           frame_id_i,
  input  logic [mfat_pkg::ANG_W-1:0]          angle_word_i,
  input  logic signed [mfat_pkg::WORD_W-1:0]  second_word_i,
  input  logic signed [mfat_pkg::WORD_W-1:0]  third_word_i,
  input  logic [mfat_pkg::BYTE_W-1:0]         sixth_byte_i,
  // result output
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                matched_o,
  output logic [mfat_pkg::OUT_IDX_W-1:0]      motor_index_o,
  output logic                                calibrating_o,
  output logic [mfat_pkg::ANG_W-1:0]          angle_o,
  output logic signed [mfat_pkg::TURN_W-1:0]  round_count_o,
  output logic signed [mfat_pkg::TURN_W-1:0]  total_angle_o,
  output logic signed [mfat_pkg::WORD_W-1:0]  speed_rpm_o,
  output logic signed [mfat_pkg::WORD_W-1:0]  torque_current_o,
  output logic signed [mfat_pkg::WORD_W-1:0]  given_current_o,
  output logic [mfat_pkg::BYTE_W-1:0]         temperature_o
);
  import mfat_pkg::*;

  cfg_t    cfg_q, cfg_d;
  q_stat_t q_stat;
  item_t   push_item;
  item_t   head_item;
  logic    push;
  logic    pop;

  // register file, identifiers take 11 bits and the calibration count 8
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_CHASSIS_BASE:  cfg_d.chassis_base   = cfg_wdata_i;
        CFG_LAUNCHER_BASE: cfg_d.launcher_base  = cfg_wdata_i;
        CFG_POKE_ID:       cfg_d.poke_id        = cfg_wdata_i;
        CFG_PITCH_ID:      cfg_d.pitch_id       = cfg_wdata_i;
        CFG_YAW_ID:        cfg_d.yaw_id         = cfg_wdata_i;
        CFG_CALIB:         cfg_d.calib_messages = cfg_wdata_i[CNT_W-1:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.chassis_base   <= RST_CHASSIS_BASE;
      cfg_q.launcher_base  <= RST_LAUNCHER_BASE;
      cfg_q.poke_id        <= RST_POKE_ID;
      cfg_q.pitch_id       <= RST_PITCH_ID;
      cfg_q.yaw_id         <= RST_YAW_ID;
      cfg_q.calib_messages <= RST_CALIB;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // front: accept and classify
  mfat_front u_front (
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .frame_id_i    (frame_id_i),
    .angle_word_i  (angle_word_i),
    .second_word_i (second_word_i),
    .third_word_i  (third_word_i),
    .sixth_byte_i  (sixth_byte_i),
    .cfg_i         (cfg_q),
    .q_stat_i      (q_stat),
    .push_o        (push),
    .item_o        (push_item)
  );

  // queue between the two sides
  mfat_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (push_item),
    .pop_i  (pop),
    .head_o (head_item),
    .stat_o (q_stat)
  );

  // back: motor entry update and result beat
  mfat_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .calib_messages_i (cfg_q.calib_messages),
    .q_stat_i         (q_stat),
    .head_i           (head_item),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .matched_o        (matched_o),
    .motor_index_o    (motor_index_o),
    .calibrating_o    (calibrating_o),
    .angle_o          (angle_o),
    .round_count_o    (round_count_o),
    .total_angle_o    (total_angle_o),
    .speed_rpm_o      (speed_rpm_o),
    .torque_current_o (torque_current_o),
    .given_current_o  (given_current_o),
    .temperature_o    (temperature_o)
  );

  // an unmatched frame reports nothing but zeros
  a_unmatched_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !matched_o |->
      angle_o == '0 && round_count_o == '0 && total_angle_o == '0 &&
      torque_current_o == '0 && calibrating_o == 1'b0)
    else $error("unmatched result beat carries data");

  // a calibrating beat gives no total angle and no decoded words
  a_calib_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && calibrating_o |->
      total_angle_o == '0 && speed_rpm_o == '0 && torque_current_o == '0 &&
      given_current_o == '0 && temperature_o == '0)
    else $error("calibrating result beat carries decoded data");

  // chassis and gimbal decodes never mix
  a_type_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> given_current_o == '0 ||
                    (speed_rpm_o == '0 && temperature_o == '0))
    else $error("result beat mixes chassis and gimbal fields");

  // queue never pops while empty
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_stat.empty)
    else $error("queue popped while empty");

endmodule

/* tb/angle_tracker_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// angle_tracker_checker: result predictor and scoreboard for the angle tracker
// follows register writes and both channels, computes the result of every
// accepted frame beat and compares each result beat field by field in order
// ----------------------------------------------------------------------------
module angle_tracker_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [mfat_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [mfat_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                            in_valid_i,
  input  logic                            in_stall_i,
  input  logic [mfat_pkg::ID_W-1:0]       frame_id_i,
  input  logic [mfat_pkg::ANG_W-1:0]      angle_word_i,
  input  logic [mfat_pkg::WORD_W-1:0]     second_word_i,
  input  logic [mfat_pkg::WORD_W-1:0]     third_word_i,
  input  logic [mfat_pkg::BYTE_W-1:0]     sixth_byte_i,
  input  logic                            out_valid_i,
  input  logic                            out_stall_i,
  input  logic                            matched_i,
  input  logic [mfat_pkg::OUT_IDX_W-1:0]  motor_index_i,
  input  logic                            calibrating_i,
  input  logic [mfat_pkg::ANG_W-1:0]      angle_i,
  input  logic [mfat_pkg::TURN_W-1:0]     round_count_i,
  input  logic [mfat_pkg::TURN_W-1:0]     total_angle_i,
  input  logic [mfat_pkg::WORD_W-1:0]     speed_rpm_i,
  input  logic [mfat_pkg::WORD_W-1:0]     torque_current_i,
  input  logic [mfat_pkg::WORD_W-1:0]     given_current_i,
  input  logic [mfat_pkg::BYTE_W-1:0]     temperature_i,
  output int                              err_count_o,
  output int                              pending_o
);
  import mfat_pkg::*;

  localparam int HALF_TURN   = COUNTS_PER_TURN / 2;

  typedef struct packed {
    logic                 matched;
    logic [OUT_IDX_W-1:0] motor;
    logic                 calibrating;
    logic [ANG_W-1:0]     angle;
    logic [TURN_W-1:0]    rounds;
    logic [TURN_W-1:0]    total;
    logic [WORD_W-1:0]    speed;
    logic [WORD_W-1:0]    torque;
    logic [WORD_W-1:0]    given;
    logic [BYTE_W-1:0]    temp;
  } feedback_t;

  // per motor tracking state
  logic [CNT_W-1:0]  msg_count  [NUM_MOTORS];
  logic [ANG_W-1:0]  prev_angle [NUM_MOTORS];
  logic [TURN_W-1:0] turns      [NUM_MOTORS];
  logic [ANG_W-1:0]  zero_angle [NUM_MOTORS];

  cfg_t      cfg;
  feedback_t due_results [$];
  int        errors;

  // chassis group first, then launcher, poke, pitch, yaw; -1 when nothing matches
  function automatic int motor_of(input logic [ID_W-1:0] id);
    logic [31:0] idv;
    logic [31:0] chassis;
    logic [31:0] launcher;
    idv      = 32'(id);
    chassis  = 32'(cfg.chassis_base);
    launcher = 32'(cfg.launcher_base);
    if (idv >= chassis && idv - chassis < CHASSIS_MOTORS) return int'(idv - chassis);
    if (idv >= launcher && idv - launcher < LAUNCHER_MOTORS)
      return CHASSIS_MOTORS + int'(idv - launcher);
    if (id == cfg.poke_id) return POKE_IDX;
    if (id == cfg.pitch_id) return PITCH_IDX;
    if (id == cfg.yaw_id) return YAW_IDX;
    return -1;
  endfunction

  function automatic feedback_t track_frame(input logic [ID_W-1:0] id,
                                            input logic [ANG_W-1:0] ang,
                                            input logic [WORD_W-1:0] w2,
                                            input logic [WORD_W-1:0] w3,
                                            input logic [BYTE_W-1:0] b6);
    feedback_t        r;
    int               m;
    logic [CNT_W-1:0] prior;
    int               diff;
    r = '0;
    m = motor_of(id);
    if (m < 0) return r;
    r.matched = 1'b1;
    r.motor   = OUT_IDX_W'(m);
    r.angle   = ang;
    prior = msg_count[m];
    if (prior != CNT_MAX) msg_count[m] = prior + 1'b1;
    // early messages only record the offset
    if (prior <= cfg.calib_messages) begin
      prev_angle[m]  = ang;
      zero_angle[m]  = ang;
      r.calibrating = 1'b1;
      r.rounds      = turns[m];
      return r;
    end
    // a jump of more than half a turn is a crossing of the turn boundary
    diff = int'(32'(ang)) - int'(32'(prev_angle[m]));
    prev_angle[m] = ang;
    if (diff > HALF_TURN) turns[m] = turns[m] - 1'b1;
    else if (diff < -HALF_TURN) turns[m] = turns[m] + 1'b1;
    r.rounds = turns[m];
    r.total  = turns[m] * 32'(COUNTS_PER_TURN) + 32'(ang) - 32'(zero_angle[m]);
    if (m <= POKE_IDX) begin
      r.speed  = w2;
      r.torque = w3;
      r.temp   = b6;
    end else begin
      r.torque = w2;
      r.given  = w3;
    end
    return r;
  endfunction

  task automatic compare_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t mismatch on %s: expected %0h, got %0h", $time, what, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    feedback_t want;
    if (!rst_ni) begin
      cfg.chassis_base   = RST_CHASSIS_BASE;
      cfg.launcher_base  = RST_LAUNCHER_BASE;
      cfg.poke_id        = RST_POKE_ID;
      cfg.pitch_id       = RST_PITCH_ID;
      cfg.yaw_id         = RST_YAW_ID;
      cfg.calib_messages = RST_CALIB;
      for (int k = 0; k < NUM_MOTORS; k++) begin
        msg_count[k]  = '0;
        prev_angle[k] = '0;
        turns[k]      = '0;
        zero_angle[k] = '0;
      end
      due_results.delete();
      errors = 0;
      err_count_o <= 0;
      pending_o   <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_CHASSIS_BASE:  cfg.chassis_base   = cfg_wdata_i;
          CFG_LAUNCHER_BASE: cfg.launcher_base  = cfg_wdata_i;
          CFG_POKE_ID:       cfg.poke_id        = cfg_wdata_i;
          CFG_PITCH_ID:      cfg.pitch_id       = cfg_wdata_i;
          CFG_YAW_ID:        cfg.yaw_id         = cfg_wdata_i;
          CFG_CALIB:         cfg.calib_messages = cfg_wdata_i[CNT_W-1:0];
          default: ;
        endcase
      end
      // result side first so a beat never meets the frame accepted at the same edge
      if (out_valid_i && !out_stall_i) begin
        if (due_results.size() == 0) begin
          errors++;
          $display("%0t result beat with nothing outstanding: expected none, got motor %0d",
                   $time, motor_index_i);
        end else begin
          want = due_results.pop_front();
          compare_field("matched", 32'(want.matched), 32'(matched_i));
          compare_field("motor_index", 32'(want.motor), 32'(motor_index_i));
          compare_field("calibrating", 32'(want.calibrating), 32'(calibrating_i));
          compare_field("angle", 32'(want.angle), 32'(angle_i));
          compare_field("round_count", want.rounds, round_count_i);
          compare_field("total_angle", want.total, total_angle_i);
          compare_field("speed_rpm", 32'(want.speed), 32'(speed_rpm_i));
          compare_field("torque_current", 32'(want.torque), 32'(torque_current_i));
          compare_field("given_current", 32'(want.given), 32'(given_current_i));
          compare_field("temperature", 32'(want.temp), 32'(temperature_i));
        end
      end
      if (in_valid_i && !in_stall_i)
        due_results.push_back(track_frame(frame_id_i, angle_word_i, second_word_i,
                                          third_word_i, sixth_byte_i));
      err_count_o <= errors;
      pending_o   <= due_results.size();
    end
  end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench of the motor feedback angle tracker
// drives directed and random feedback frames through several register
// settings and handshake phases; a separate checker predicts and compares
// ----------------------------------------------------------------------------
module tb;
  import mfat_pkg::*;

  // cycles allowed after the last result before a register write or the verdict
  localparam int DRAIN_CYCLES = 8;
  // length of the long result side hold-off
  localparam int HOLD_CYCLES  = 200;

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  cfg_we      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata   = '0;
  logic                  in_valid    = 1'b0;
  logic                  in_stall;
  logic [ID_W-1:0]       frame_id    = '0;
  logic [ANG_W-1:0]      angle_word  = '0;
  logic [WORD_W-1:0]     second_word = '0;
  logic [WORD_W-1:0]     third_word  = '0;
  logic [BYTE_W-1:0]     sixth_byte  = '0;
  logic                  out_valid;
  logic                  out_stall   = 1'b0;
  logic                  matched;
  logic [OUT_IDX_W-1:0]  motor_index;
  logic                  calibrating;
  logic [ANG_W-1:0]      angle;
  logic [TURN_W-1:0]     round_count;
  logic [TURN_W-1:0]     total_angle;
  logic [WORD_W-1:0]     speed_rpm;
  logic [WORD_W-1:0]     torque_current;
  logic [WORD_W-1:0]     given_current;
  logic [BYTE_W-1:0]     temperature;

  // idling percentages of the current phase, frame side and result side
  int   gap_pct   = 0;
  int   stall_pct = 0;
  // a one-cycle request starts the long hold-off, counted down below
  logic hold_req  = 1'b0;
  int   hold_left = 0;

  int   err_count;
  int   pending;

  // register copy used to aim frames at the motors currently mapped
  cfg_t cur_cfg;

  motor_feedback_angle_tracker_top u_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .frame_id_i       (frame_id),
    .angle_word_i     (angle_word),
    .second_word_i    (second_word),
    .third_word_i     (third_word),
    .sixth_byte_i     (sixth_byte),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .matched_o        (matched),
    .motor_index_o    (motor_index),
    .calibrating_o    (calibrating),
    .angle_o          (angle),
    .round_count_o    (round_count),
    .total_angle_o    (total_angle),
    .speed_rpm_o      (speed_rpm),
    .torque_current_o (torque_current),
    .given_current_o  (given_current),
    .temperature_o    (temperature)
  );

  angle_tracker_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .frame_id_i       (frame_id),
    .angle_word_i     (angle_word),
    .second_word_i    (second_word),
    .third_word_i     (third_word),
    .sixth_byte_i     (sixth_byte),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .matched_i        (matched),
    .motor_index_i    (motor_index),
    .calibrating_i    (calibrating),
    .angle_i          (angle),
    .round_count_i    (round_count),
    .total_angle_i    (total_angle),
    .speed_rpm_i      (speed_rpm),
    .torque_current_i (torque_current),
    .given_current_i  (given_current),
    .temperature_i    (temperature),
    .err_count_o      (err_count),
    .pending_o        (pending)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // long hold-off countdown, restarted by a request pulse
  always @(posedge clk) begin
    if (hold_req) hold_left <= HOLD_CYCLES;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  // result side stall: the hold-off or a random stall at the phase rate
  always @(posedge clk) begin
    out_stall <= (hold_left != 0) || ($urandom_range(99) < stall_pct);
  end

  // hard stop in case the block hangs
  initial begin
    #5_000_000;
    $display("tb: errors");
    $finish;
  end

  // one frame beat: random gaps first, then hold the payload until accepted;
  // valid stays high on return so a following beat can go out back to back
  task automatic send_frame(input logic [ID_W-1:0] id, input logic [ANG_W-1:0] ang,
                            input logic [WORD_W-1:0] w2, input logic [WORD_W-1:0] w3,
                            input logic [BYTE_W-1:0] b6);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    frame_id    <= id;
    angle_word  <= ang;
    second_word <= w2;
    third_word  <= w3;
    sixth_byte  <= b6;
    do @(posedge clk); while (in_stall);
  endtask

  // stop offering frames, wait out every result, then let the block settle
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // write enable stays high here; apply_config drops it after the last write
  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic apply_config(input cfg_t c);
    cur_cfg = c;
    write_reg(CFG_CHASSIS_BASE, c.chassis_base);
    write_reg(CFG_LAUNCHER_BASE, c.launcher_base);
    write_reg(CFG_POKE_ID, c.poke_id);
    write_reg(CFG_PITCH_ID, c.pitch_id);
    write_reg(CFG_YAW_ID, c.yaw_id);
    // upper data bits are junk for the 8-bit calibration register
    write_reg(CFG_CALIB, {3'($urandom_range(7)), c.calib_messages});
    cfg_we <= 1'b0;
  endtask

  function automatic cfg_t random_ids(input logic [CNT_W-1:0] calib);
    cfg_t c;
    c.chassis_base   = ID_W'($urandom_range(2047));
    c.launcher_base  = ID_W'($urandom_range(2047));
    c.poke_id        = ID_W'($urandom_range(2047));
    c.pitch_id       = ID_W'($urandom_range(2047));
    c.yaw_id         = ID_W'($urandom_range(2047));
    c.calib_messages = calib;
    return c;
  endfunction

  // random frames: most go to the yaw motor so its count runs into saturation,
  // many to the other mapped motors, a few to any identifier at all
  task automatic send_random(input int n);
    logic [ID_W-1:0]  id;
    logic [ANG_W-1:0] ang;
    int               pick;
    repeat (n) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        id = cur_cfg.yaw_id;
      end else if (pick < 92) begin
        pick = $urandom_range(NUM_MOTORS - 1);
        if (pick < CHASSIS_MOTORS) id = cur_cfg.chassis_base + ID_W'(pick);
        else if (pick < POKE_IDX) id = cur_cfg.launcher_base + ID_W'(pick - CHASSIS_MOTORS);
        else if (pick == POKE_IDX) id = cur_cfg.poke_id;
        else if (pick == PITCH_IDX) id = cur_cfg.pitch_id;
        else id = cur_cfg.yaw_id;
      end else begin
        id = ID_W'($urandom_range(2047));
      end
      // mostly encoder-range angles, which jump across the turn boundary often
      pick = $urandom_range(9);
      if (pick < 7) ang = ANG_W'($urandom_range(COUNTS_PER_TURN - 1));
      else if (pick < 9) ang = ANG_W'($urandom);
      else if ($urandom_range(1) == 0) ang = ANG_W'($urandom_range(15));
      else ang = ANG_W'(COUNTS_PER_TURN - 1 - $urandom_range(15));
      send_frame(id, ang, WORD_W'($urandom), WORD_W'($urandom), BYTE_W'($urandom));
    end
  endtask

  initial begin
    cfg_t c;
    int   base;
    cur_cfg.chassis_base   = RST_CHASSIS_BASE;
    cur_cfg.launcher_base  = RST_LAUNCHER_BASE;
    cur_cfg.poke_id        = RST_POKE_ID;
    cur_cfg.pitch_id       = RST_PITCH_ID;
    cur_cfg.yaw_id         = RST_YAW_ID;
    cur_cfg.calib_messages = RST_CALIB;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, reset register values: unmatched ids at both ends of the range,
    // then every default id once, all still in calibration
    send_frame(11'd0, 16'hFFFF, 16'h7FFF, 16'h8000, 8'hFF);
    send_frame(11'd2047, 16'h0000, 16'h0000, 16'h0000, 8'h00);
    send_frame(11'd513, 16'd100, 16'h8000, 16'h7FFF, 8'h00);
    send_frame(11'd514, 16'd100, 16'h1234, 16'hFEDC, 8'h5A);
    send_frame(11'd515, 16'd100, 16'hFFFF, 16'h0001, 8'hA5);
    send_frame(11'd516, 16'd100, 16'h0001, 16'hFFFF, 8'h01);
    send_frame(11'd517, 16'd100, 16'h7FFF, 16'h7FFF, 8'hFE);
    send_frame(11'd518, 16'd100, 16'h8000, 16'h8000, 8'h80);
    send_frame(11'd519, 16'd100, 16'h5555, 16'hAAAA, 8'h7F);
    send_frame(11'd520, 16'd100, 16'hAAAA, 16'h5555, 8'h33);
    send_frame(11'd521, 16'd100, 16'h0F0F, 16'hF0F0, 8'hCC);
    send_frame(11'd522, 16'd100, 16'hF0F0, 16'h0F0F, 8'h0F);
    settle();

    // no calibration messages from here: turn boundary crossings both ways,
    // jumps of exactly half a turn (no crossing), the 16-bit extremes
    c = cur_cfg;
    c.calib_messages = '0;
    apply_config(c);
    send_frame(11'd513, 16'd8000, 16'h7FFF, 16'h8000, 8'hFF);
    send_frame(11'd513, 16'd100, 16'h8000, 16'h7FFF, 8'h00);
    send_frame(11'd513, 16'd4196, 16'h0001, 16'hFFFF, 8'h11);
    send_frame(11'd513, 16'd100, 16'hFFFF, 16'h0001, 8'h22);
    send_frame(11'd513, 16'd4197, 16'h1111, 16'h2222, 8'h44);
    send_frame(11'd513, 16'hFFFF, 16'h3333, 16'h4444, 8'h88);
    send_frame(11'd513, 16'h0000, 16'h5555, 16'h6666, 8'hEE);
    send_frame(11'd522, 16'd8191, 16'h8000, 16'h7FFF, 8'hFF);
    send_frame(11'd521, 16'd0, 16'h7FFF, 16'h8000, 8'hFF);
    send_frame(11'd519, 16'd8191, 16'h8000, 16'h7FFF, 8'hFF);
    send_frame(11'd518, 16'd4296, 16'h7FFF, 16'h8000, 8'h00);
    settle();

    // random ids, no calibration, no idling
    apply_config(random_ids('0));
    send_random(80);
    settle();

    // short calibration, frame side idles often
    apply_config(random_ids(8'd3));
    gap_pct = 48;
    send_random(80);
    settle();

    // overlapping groups: launcher, poke and pitch are shadowed by the chassis ids
    base = $urandom_range(2000);
    c.chassis_base   = ID_W'(base);
    c.launcher_base  = ID_W'(base + 2);
    c.poke_id        = ID_W'(base + 1);
    c.pitch_id       = ID_W'(base + 3);
    c.yaw_id         = ID_W'(base + 10);
    c.calib_messages = CNT_W'($urandom_range(2, 6));
    apply_config(c);
    gap_pct   = 0;
    stall_pct = 48;
    send_random(80);
    settle();

    // ids at the ends of the range; chassis at the top leaves one id in its group
    c.chassis_base   = 11'd2047;
    c.launcher_base  = 11'd0;
    c.poke_id        = 11'd0;
    c.pitch_id       = 11'd2047;
    c.yaw_id         = 11'd1000;
    c.calib_messages = 8'd10;
    apply_config(c);
    gap_pct   = 7;
    stall_pct = 7;
    send_random(80);
    settle();

    // back to the default ids; hold the result side off while frames keep
    // coming so the block backs up and stalls its input
    c.chassis_base   = RST_CHASSIS_BASE;
    c.launcher_base  = RST_LAUNCHER_BASE;
    c.poke_id        = RST_POKE_ID;
    c.pitch_id       = RST_PITCH_ID;
    c.yaw_id         = RST_YAW_ID;
    c.calib_messages = 8'd1;
    apply_config(c);
    gap_pct   = 0;
    stall_pct = 0;
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    send_random(40);
    // frame side pauses until everything has drained
    settle();
    gap_pct   = 7;
    stall_pct = 7;
    send_random(20);
    settle();

    // largest calibration count: no motor ever leaves calibration, since
    // a count stuck at 255 still calibrates
    apply_config(random_ids(8'd255));
    gap_pct   = 48;
    stall_pct = 0;
    send_random(60);
    settle();

    // one below: the saturated yaw motor tracks, the others calibrate
    c = random_ids(8'd254);
    apply_config(c);
    gap_pct   = 0;
    stall_pct = 48;
    send_random(60);
    settle();

    if (err_count == 0 && pending == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

/* motor_feedback_angle_tracker_top.f */
rtl/mfat_pkg.sv
rtl/mfat_front.sv
rtl/mfat_queue.sv
rtl/mfat_back.sv
rtl/motor_feedback_angle_tracker_top.sv
tb/angle_tracker_checker.sv
tb/tb.sv
